@@ rtl/chsw_pkg.sv @@
// chsw_pkg: shared types and constants of the calibrated height block
// holds port widths, reset values, defaults and the divider control/status structs
// no dependencies
package chsw_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 12;
    localparam int MEAN_W     = 12;
    localparam int PCT_W      = 7;
    localparam int DELTA_W    = 12;
    localparam int PCT_NUM_W  = 19;   // (4095 * 100) fits in 19 bits
    localparam int STEP_W     = 4;    // divider step count, at most SAMPLE_W

    // parameter defaults
    localparam int WINDOW_SIZE_DEF   = 5;
    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int SETTLE_FACTOR_DEF = 15;

    // register reset and percentage scale
    localparam logic [DELTA_W-1:0] DELTA_RESET = 12'd993;
    localparam logic [PCT_W-1:0]   PCT_SCALE   = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_MAX     = 7'd100;

    // command codes
    localparam logic CMD_SAMPLE    = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/chsw_cell.sv @@
// chsw_cell: one slot of the sample window chain
// loads its neighbor's word when enabled, cleared by reset
// depends on nothing
module chsw_cell #(
    parameter int W = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/chsw_div.sv @@
// chsw_div: restoring divider, one quotient bit per cycle
// the caller hands in the divisor pre-shifted to the top quotient bit
// depends on chsw_pkg
module chsw_div #(
    parameter int W = 19
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  chsw_pkg::t_div_ctrl           i_ctrl,
    input  logic [W-1:0]                  i_num,
    input  logic [W-1:0]                  i_dsh,
    output chsw_pkg::t_div_stat           o_stat,
    output logic [chsw_pkg::SAMPLE_W-1:0] o_quo
);

    localparam int QW = chsw_pkg::SAMPLE_W;

    logic [W-1:0]                r_rem, n_rem;
    logic [W-1:0]                r_dsh, n_dsh;
    logic [QW-1:0]               r_quo, n_quo;
    logic [chsw_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic                        r_done, n_done;
    logic                        w_ge;

    assign w_ge = (r_rem >= r_dsh);

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_ctrl.start) begin
            n_rem = i_num;
            n_dsh = i_dsh;
            n_quo = '0;
            n_cnt = i_ctrl.steps;
        end else if (r_cnt != '0) begin
            if (w_ge) begin
                n_rem = r_rem - r_dsh;
            end
            n_quo  = {r_quo[QW-2:0], w_ge};
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == chsw_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

@@ rtl/calibrated_height_from_sample_window.sv @@
// calibrated_height_from_sample_window: moving average with self calibration
// accepts a word only while idle; each word runs through the window rotation (N = WINDOW_SIZE),
// the mean, the reference update and the percentage check, then through the serial percentage
// divider (7 steps) when the percentage needs it, and waits in done until the output is free
// synchronous active-low reset clears the window, counters, reference and flag, and sets delta to 993
// depends on chsw_pkg, chsw_cell, chsw_div
module calibrated_height_from_sample_window #(
    parameter int WINDOW_SIZE   = chsw_pkg::WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS   = chsw_pkg::SAMPLE_BITS_DEF,
    parameter int SETTLE_FACTOR = chsw_pkg::SETTLE_FACTOR_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_command,
    input  logic [chsw_pkg::SAMPLE_W-1:0] i_sample,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [chsw_pkg::MEAN_W-1:0]  o_window_mean,
    output logic [chsw_pkg::PCT_W-1:0]   o_height_percent,
    output logic                         o_is_calibrated,
    // full scale delta write port
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [chsw_pkg::DELTA_W-1:0] i_cfg_data
);

    // kept sample width: converter word masked to SAMPLE_BITS
    localparam int KEPT_W = (SAMPLE_BITS < chsw_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : chsw_pkg::SAMPLE_W;
    localparam int CNT_W  = $clog2(WINDOW_SIZE);
    localparam int SUM_W  = KEPT_W + $clog2(WINDOW_SIZE);
    localparam int DIV_W  = chsw_pkg::PCT_NUM_W;

    localparam int SETTLE_COUNT = WINDOW_SIZE * SETTLE_FACTOR;
    localparam int SEEN_W       = $clog2(SETTLE_COUNT + 2);
    localparam logic [SEEN_W-1:0] SEEN_SAT = SEEN_W'(SETTLE_COUNT + 1);

    // mean = (2*sum + N) / (2N) = (sum + floor(N/2)) / N, taken by a reciprocal
    // multiply that is exact for every sum below N * 2^KEPT_W
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int MEAN_SH = SUM_W + $clog2(WINDOW_SIZE);
    localparam longint MEAN_RECIP_L =
        ((longint'(1) << MEAN_SH) + longint'(WINDOW_SIZE) - 1) / longint'(WINDOW_SIZE);
    localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(MEAN_RECIP_L);
    localparam logic [SUM_W-1:0]   MEAN_OFS   = SUM_W'(WINDOW_SIZE / 2);

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SUM    = 3'd1;
    localparam logic [2:0] S_MEAN   = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_PCHK   = 3'd4;
    localparam logic [2:0] S_PDIV   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]                   r_state, n_state;
    logic                         r_cmd;
    logic [CNT_W-1:0]             r_cnt;
    logic [SUM_W-1:0]             r_acc;
    logic [SEEN_W-1:0]            r_seen;
    logic [chsw_pkg::MEAN_W-1:0]  r_mean;
    logic [chsw_pkg::MEAN_W-1:0]  r_ref, n_ref;
    logic                         r_cal, n_cal;
    logic [chsw_pkg::PCT_NUM_W-1:0] r_num;
    logic                         r_pos;
    logic [chsw_pkg::PCT_W-1:0]   r_pct;
    logic [chsw_pkg::DELTA_W-1:0] r_delta;

    logic                         r_out_valid;
    logic [chsw_pkg::MEAN_W-1:0]  r_out_mean;
    logic [chsw_pkg::PCT_W-1:0]   r_out_pct;
    logic                         r_out_cal;

    logic                         w_accept;
    logic                         w_shift_in;
    logic                         w_cell_en;
    logic [KEPT_W-1:0]            w_cell_d0;
    logic [KEPT_W-1:0]            w_cell_q [WINDOW_SIZE];
    logic                         w_out_free;
    logic                         w_load_out;

    logic [SUM_W-1:0]             w_mean_x;
    logic [PROD_W-1:0]            w_mean_prod;

    logic [chsw_pkg::DELTA_W-1:0] w_span;
    logic [DIV_W-1:0]             w_pct_lim;
    logic [DIV_W-1:0]             w_pct_dsh;
    logic [chsw_pkg::MEAN_W-1:0]  w_diff;
    logic [chsw_pkg::PCT_W-1:0]   w_pct_quo;

    chsw_pkg::t_div_ctrl          w_div_ctrl;
    chsw_pkg::t_div_stat          w_div_stat;
    logic [DIV_W-1:0]             w_div_num;
    logic [DIV_W-1:0]             w_div_dsh;
    logic [chsw_pkg::SAMPLE_W-1:0] w_div_quo;

    // handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load_out  = (r_state == S_DONE) && w_out_free;

    // window chain: a sample shifts in at cell 0, during summing the row rotates
    // and the last cell feeds the accumulator; after N rotations the order is restored
    assign w_shift_in = w_accept && (i_command == chsw_pkg::CMD_SAMPLE);
    assign w_cell_en  = w_shift_in || (r_state == S_SUM);
    assign w_cell_d0  = w_shift_in ? i_sample[KEPT_W-1:0] : w_cell_q[WINDOW_SIZE-1];

    for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
        chsw_cell #(
            .W (KEPT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_cell_en),
            .i_d     ((g == 0) ? w_cell_d0 : w_cell_q[(g == 0) ? 0 : g - 1]),
            .o_q     (w_cell_q[g])
        );
    end

    // rounded mean from the finished sum, quotient sits above MEAN_SH
    assign w_mean_x    = r_acc + MEAN_OFS;
    assign w_mean_prod = PROD_W'(w_mean_x) * PROD_W'(MEAN_RECIP);

    // percentage terms, a zero delta acts as one
    assign w_span    = (r_delta == '0) ? chsw_pkg::DELTA_W'(1) : r_delta;
    assign w_pct_lim = DIV_W'(w_span) << chsw_pkg::PCT_W;
    assign w_pct_dsh = DIV_W'(w_span) << (chsw_pkg::PCT_W - 1);
    assign w_pct_quo = w_div_quo[chsw_pkg::PCT_W-1:0];

    // reference update: self calibration on the settling sample, or a calibrate command once calibrated
    always_comb begin
        n_ref = r_ref;
        n_cal = r_cal;
        if (r_cmd == chsw_pkg::CMD_CALIBRATE) begin
            if (r_cal) begin
                n_ref = r_mean;
            end
        end else if (!r_cal && (r_seen == SEEN_SAT)) begin
            n_ref = r_mean;
            n_cal = 1'b1;
        end
    end

    assign w_diff = n_ref - r_mean;

    // percentage divider requests
    always_comb begin
        w_div_ctrl.start = 1'b0;
        w_div_ctrl.steps = chsw_pkg::STEP_W'(chsw_pkg::PCT_W);
        w_div_num        = DIV_W'(r_num);
        w_div_dsh        = w_pct_dsh;
        case (r_state)
            S_PCHK: begin
                w_div_ctrl.start = r_pos && (DIV_W'(r_num) < w_pct_lim);
            end
            default: begin
                w_div_ctrl.start = 1'b0;
            end
        endcase
    end

    chsw_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_div_ctrl),
        .i_num   (w_div_num),
        .i_dsh   (w_div_dsh),
        .o_stat  (w_div_stat),
        .o_quo   (w_div_quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_SUM;
            S_SUM:    if (r_cnt == '0) n_state = S_MEAN;
            S_MEAN:   n_state = S_UPD;
            S_UPD:    n_state = S_PCHK;
            S_PCHK:   n_state = w_div_ctrl.start ? S_PDIV : S_DONE;
            S_PDIV:   if (w_div_stat.done) n_state = S_DONE;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= '0;
            r_ref       <= '0;
            r_cal       <= 1'b0;
            r_mean      <= '0;
            r_delta     <= chsw_pkg::DELTA_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_delta <= i_cfg_data;
            end
            // samples seen saturates one past the settling count
            if (w_shift_in && (r_seen != SEEN_SAT)) begin
                r_seen <= r_seen + 1'b1;
            end
            if (r_state == S_MEAN) begin
                r_mean <= chsw_pkg::MEAN_W'(w_mean_prod[MEAN_SH +: KEPT_W]);
            end
            if (r_state == S_UPD) begin
                r_ref <= n_ref;
                r_cal <= n_cal;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath words
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
            r_cnt <= CNT_W'(WINDOW_SIZE - 1);
            r_acc <= '0;
        end else if (r_state == S_SUM) begin
            r_cnt <= r_cnt - 1'b1;
            r_acc <= r_acc + SUM_W'(w_cell_q[WINDOW_SIZE-1]);
        end
        if (r_state == S_UPD) begin
            r_pos <= (n_ref > r_mean);
            r_num <= chsw_pkg::PCT_NUM_W'(w_diff) *
                     chsw_pkg::PCT_NUM_W'(chsw_pkg::PCT_SCALE);
        end
        // no positive difference gives zero, a quotient of 128 or more clamps at once
        if ((r_state == S_PCHK) && !w_div_ctrl.start) begin
            r_pct <= r_pos ? chsw_pkg::PCT_MAX : '0;
        end
        if ((r_state == S_PDIV) && w_div_stat.done) begin
            r_pct <= (w_pct_quo > chsw_pkg::PCT_MAX) ? chsw_pkg::PCT_MAX : w_pct_quo;
        end
        if (w_load_out) begin
            r_out_mean <= r_mean;
            r_out_pct  <= r_pct;
            r_out_cal  <= r_cal;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_window_mean    = r_out_mean;
    assign o_height_percent = r_out_pct;
    assign o_is_calibrated  = r_out_cal;

    // the reference stays zero until calibration
    a_ref_zero_uncal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cal |-> (r_ref == '0))
        else $error("reference set before calibration");

    // calibration is never withdrawn
    a_cal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal |=> r_cal)
        else $error("calibrated flag dropped");

    // the divider is never restarted while busy
    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_ctrl.start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    // a nonzero height needs a calibrated reference, and stays within 100
    a_pct_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_pct <= chsw_pkg::PCT_MAX) &&
                         ((r_out_pct == '0) || r_out_cal)))
        else $error("height percent out of range or uncalibrated");

    // the sample counter never passes its saturation point
    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_SAT)
        else $error("sample counter past saturation");

endmodule

@@ test/tb_calibrated_height_from_sample_window.sv @@
// tb_calibrated_height_from_sample_window: self-checking bench for the windowed height block
// predicts every result word in step with the accepted input words and compares field by field
// depends on chsw_pkg and calibrated_height_from_sample_window
module tb_calibrated_height_from_sample_window;
    timeunit 1ns;
    timeprecision 1ps;

    import chsw_pkg::*;

    localparam int WIN          = WINDOW_SIZE_DEF;
    localparam int SETTLE_COUNT = WINDOW_SIZE_DEF * SETTLE_FACTOR_DEF;
    // no word moving on any channel for this long is taken as a hang
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_WORDS  = 165;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [PCT_W-1:0]  percent;
        logic              flag;
    } height_report_t;

    // receiver pacing modes, one picked at random whenever stall_phase[6:0] reaches 127
    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_CHOPPY,
        RX_BURSTY
    } rx_pace_t;

    // dut ports, the driven inputs known from time zero
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_command = CMD_SAMPLE;
    logic [SAMPLE_W-1:0] in_sample = '0;
    logic                out_stall = 1'b1;
    logic                cfg_valid = 1'b0;
    logic [DELTA_W-1:0]  cfg_data = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [MEAN_W-1:0]   o_window_mean;
    logic [PCT_W-1:0]    o_height_percent;
    logic                o_is_calibrated;
    logic                o_cfg_ready;

    // predictor state, mirrors the block after every accepted word
    logic [SAMPLE_W-1:0] window_slots [WIN];
    int                  fill_slot;
    int                  samples_counted;
    logic [MEAN_W-1:0]   reference_mean;
    logic                is_referenced;
    logic [MEAN_W-1:0]   current_mean;
    logic [DELTA_W-1:0]  delta_setting;

    height_report_t      pending_reports [$];
    height_report_t      oldest_report;

    // bookkeeping
    int       mismatch_count = 0;
    int       words_sent = 0;
    int       calibrate_words = 0;
    int       results_checked = 0;
    int       delta_writes = 0;
    int       quiet_cycles = 0;

    // sender shaping
    int       burst_left = 0;
    bit       sender_steady = 1'b0;
    int       drift_level = 2048;
    int       drift_spread = 200;

    // receiver shaping
    rx_pace_t stall_mode = RX_FREE;
    int       stall_phase = 0;
    int       hold_left = 0;
    int       holds_asked = 0;
    int       holds_served = 0;

    calibrated_height_from_sample_window DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (in_command),
        .i_sample         (in_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_window_mean    (o_window_mean),
        .o_height_percent (o_height_percent),
        .o_is_calibrated  (o_is_calibrated),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        foreach (window_slots[k]) window_slots[k] = '0;
        fill_slot       = 0;
        samples_counted = 0;
        reference_mean  = '0;
        is_referenced   = 1'b0;
        current_mean    = '0;
        delta_setting   = DELTA_RESET;
    end

    // rounded mean of the window: (2*sum + N) / (2*N)
    function automatic logic [MEAN_W-1:0] rounded_window_mean();
        int unsigned total;
        total = 0;
        foreach (window_slots[k]) total += window_slots[k];
        return MEAN_W'((2 * total + WIN) / (2 * WIN));
    endfunction

    // truncated percentage below the reference, clamped to 0..100
    function automatic logic [PCT_W-1:0] height_of(input logic [MEAN_W-1:0] ref_lvl,
                                                   input logic [MEAN_W-1:0] mean);
        int unsigned span;
        int unsigned q;
        // a zero delta counts as one, so any drop saturates
        span = (delta_setting == '0) ? 1 : delta_setting;
        if (ref_lvl <= mean) return '0;
        q = (int'(ref_lvl) - int'(mean)) * int'(PCT_SCALE) / span;
        return (q > PCT_MAX) ? PCT_MAX : PCT_W'(q);
    endfunction

    // advance the predicted state by one accepted word and queue its result
    task automatic predict_report(input logic cmd, input logic [SAMPLE_W-1:0] smp);
        height_report_t rep;
        if (cmd == CMD_SAMPLE) begin
            window_slots[fill_slot] = smp;
            fill_slot = (fill_slot == WIN - 1) ? 0 : fill_slot + 1;
            // counter saturates one past the settle count
            if (samples_counted <= SETTLE_COUNT) samples_counted++;
            current_mean = rounded_window_mean();
            // self calibration on the first sample past the settle count
            if (!is_referenced && samples_counted > SETTLE_COUNT) begin
                reference_mean = current_mean;
                is_referenced  = 1'b1;
            end
        end else begin
            current_mean = rounded_window_mean();
            // a calibrate before self calibration only reports
            if (is_referenced) reference_mean = current_mean;
        end
        rep.mean    = current_mean;
        rep.percent = height_of(reference_mean, current_mean);
        rep.flag    = is_referenced;
        pending_reports.push_back(rep);
    endtask

    // drop the input valid and leave the channel quiet for a gap set by the argument
    task automatic idle_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // offer one word, hold it until accepted, then maybe open a gap between bursts
    task automatic offer_word(input logic cmd, input logic [SAMPLE_W-1:0] smp);
        in_valid   <= 1'b1;
        in_command <= cmd;
        in_sample  <= smp;
        do @(posedge clk); while (o_in_stall);
        predict_report(cmd, smp);
        words_sent++;
        if (cmd == CMD_CALIBRATE) calibrate_words++;
        if (!sender_steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                // gap lengths cover every phase of the block's per-word work
                idle_sender($urandom_range(1, 40));
            end else begin
                burst_left--;
            end
        end
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic settle_block();
        idle_sender(1);
        while (pending_reports.size() != 0) @(posedge clk);
    endtask

    // write the full scale delta while the block is idle
    task automatic write_full_scale(input logic [DELTA_W-1:0] value);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        delta_setting = value;
        delta_writes++;
    endtask

    // random traffic: mostly samples around a drifting level, some full-range
    // noise, and a few calibrate commands with junk in the sample field
    task automatic pick_traffic_word(output logic cmd, output logic [SAMPLE_W-1:0] smp);
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 3) drift_level = $urandom_range(0, 4095);
        else drift_level = drift_level + int'($urandom_range(0, 40)) - 20;
        if (drift_level < 0) drift_level = 0;
        if (drift_level > 4095) drift_level = 4095;
        cmd = CMD_SAMPLE;
        if (roll < 9) begin
            cmd = CMD_CALIBRATE;
            smp = SAMPLE_W'($urandom);
        end else if (roll < 30) begin
            smp = SAMPLE_W'($urandom);
        end else begin
            v = drift_level + int'($urandom_range(0, 2 * drift_spread)) - drift_spread;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            smp = SAMPLE_W'(v);
        end
    endtask

    // before any reference: extremes, bit patterns, ignored calibrate commands
    task automatic test_power_up();
        offer_word(CMD_CALIBRATE, 12'hFFF);
        offer_word(CMD_SAMPLE, 12'hFFF);
        offer_word(CMD_SAMPLE, 12'h000);
        offer_word(CMD_SAMPLE, 12'hAAA);
        offer_word(CMD_SAMPLE, 12'h555);
        repeat (5) offer_word(CMD_SAMPLE, 12'hFFF);
        offer_word(CMD_CALIBRATE, 12'h000);
        offer_word(CMD_SAMPLE, 12'h000);
    endtask

    // run samples past the settle count so the block takes its own reference
    task automatic test_self_calibration();
        logic [SAMPLE_W-1:0] smp;
        while (!is_referenced) begin
            smp = SAMPLE_W'($urandom_range(1700, 2300));
            offer_word(CMD_SAMPLE, smp);
        end
        repeat (3) offer_word(CMD_SAMPLE, SAMPLE_W'($urandom_range(1500, 2000)));
        settle_block();
    endtask

    // calibrate command, clamping, delta extremes, zero delta, reference not above mean
    task automatic test_calibrate_and_clamp();
        repeat (5) offer_word(CMD_SAMPLE, 12'hFFF);
        offer_word(CMD_CALIBRATE, 12'h000);
        offer_word(CMD_SAMPLE, 12'h000);
        repeat (4) offer_word(CMD_SAMPLE, 12'h000);
        write_full_scale(12'hFFF);
        offer_word(CMD_SAMPLE, 12'h000);
        offer_word(CMD_SAMPLE, 12'hFFF);
        write_full_scale(12'd1);
        offer_word(CMD_SAMPLE, 12'h000);
        write_full_scale(12'd0);
        offer_word(CMD_SAMPLE, 12'h000);
        offer_word(CMD_CALIBRATE, 12'hFFF);
        offer_word(CMD_SAMPLE, 12'hFFF);
        offer_word(CMD_SAMPLE, 12'h800);
        write_full_scale(DELTA_RESET);
    endtask

    // receiver holds off for a long stretch while the sender keeps pushing
    task automatic test_input_backpressure();
        logic                cmd;
        logic [SAMPLE_W-1:0] smp;
        settle_block();
        sender_steady = 1'b1;
        holds_asked++;
        repeat (14) begin
            pick_traffic_word(cmd, smp);
            offer_word(cmd, smp);
        end
        sender_steady = 1'b0;
        settle_block();
    endtask

    // long random run over several delta settings, extremes among them
    task automatic test_random_traffic();
        logic [DELTA_W-1:0]  plan [6];
        logic                cmd;
        logic [SAMPLE_W-1:0] smp;
        plan[0] = DELTA_RESET;
        plan[1] = 12'd1;
        plan[2] = 12'hFFF;
        plan[3] = DELTA_W'($urandom_range(1, 4095));
        plan[4] = DELTA_W'($urandom_range(1, 200));
        plan[5] = DELTA_W'($urandom_range(2000, 4095));
        foreach (plan[p]) begin
            write_full_scale(plan[p]);
            sender_steady = ($urandom_range(0, 3) == 0);
            drift_spread  = $urandom_range(5, 600);
            repeat (PHASE_WORDS) begin
                pick_traffic_word(cmd, smp);
                offer_word(cmd, smp);
            end
        end
        sender_steady = 1'b0;
        settle_block();
    endtask

    // receiver: own stall pattern, plus a long hold when the pressure test asks
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end else begin
            case (stall_mode)
                RX_FREE:   out_stall <= 1'b0;
                RX_LIGHT:  out_stall <= ($urandom_range(0, 7) == 0);
                RX_CHOPPY: out_stall <= ($urandom_range(0, 1) == 1);
                default:   out_stall <= (stall_phase[5] == 1'b1);
            endcase
        end
        stall_phase <= stall_phase + 1;
        if (stall_phase[6:0] == 7'd127) stall_mode <= rx_pace_t'($urandom_range(0, 3));
    end

    // result checker: every accepted word against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: result word with nothing expected: mean %0d pct %0d flag %0b",
                         $time, o_window_mean, o_height_percent, o_is_calibrated);
                mismatch_count++;
            end else begin
                oldest_report = pending_reports.pop_front();
                results_checked++;
                if (o_window_mean !== oldest_report.mean) begin
                    $display("%0t: window_mean expected %0d, got %0d",
                             $time, oldest_report.mean, o_window_mean);
                    mismatch_count++;
                end
                if (o_height_percent !== oldest_report.percent) begin
                    $display("%0t: height_percent expected %0d, got %0d",
                             $time, oldest_report.percent, o_height_percent);
                    mismatch_count++;
                end
                if (o_is_calibrated !== oldest_report.flag) begin
                    $display("%0t: is_calibrated expected %0b, got %0b",
                             $time, oldest_report.flag, o_is_calibrated);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: ends the run when no word moves on any channel for too long
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // reset held low from time zero, released once
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_self_calibration();
        test_calibrate_and_clamp();
        test_input_backpressure();
        test_random_traffic();

        // wait for every prediction to come back; give the block time to show any stray result
        settle_block();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input words (%0d calibrate commands), %0d results compared,",
                 words_sent, calibrate_words, results_checked);
        $display("%0d full scale delta writes including 0, 1 and 4095, one long receiver hold",
                 delta_writes);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
